[sv/bbd_pkg.sv]
// bbd_pkg: shared types, codes and helpers for the b-dot detumble block
// used by bbd_lane, bbd_merge and bdot_bang_bang_detumble
// no dependencies
package bbd_pkg;

    // coil drive codes
    typedef enum logic [1:0] {
        COIL_OFF = 2'd0,
        COIL_FWD = 2'd1,
        COIL_REV = 2'd2
    } t_coil;

    // configuration register indexes
    localparam logic [1:0] REG_ALPHA     = 2'd0;
    localparam logic [1:0] REG_GAIN      = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;

    // configuration reset values
    localparam logic [15:0] ALPHA_RST     = 16'd6554;
    localparam logic [15:0] GAIN_RST      = 16'd256;
    localparam logic [31:0] THRESHOLD_RST = 32'd100;

    // milliseconds per second
    localparam int unsigned SCALE_MS = 1000;

    // widths of the moment numerator and of the threshold bound
    localparam int NUM_W   = 59;
    localparam int BOUND_W = 65;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ABS,
        S_ALPHA,
        S_FILT,
        S_CHG,
        S_GAIN,
        S_SCALE,
        S_DONE
    } t_state;

    // per-lane control from the sequencer
    typedef struct packed {
        logic load;
        logic seed;
        logic commit;
    } t_lane_ctl;

    // per-lane result toward the merge stage
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic             neg;
        logic             nonzero;
    } t_lane_res;

    // clamp to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7fff_ffff) begin
            r = 32'sh7fff_ffff;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[sv/bbd_lane.sv]
// bbd_lane: one axis of the detumble datapath, filter state and moment numerator
// depends on bbd_pkg
module bbd_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  bbd_pkg::t_lane_ctl      i_ctl,
    input  logic signed [15:0]      i_raw,
    input  logic [15:0]             i_alpha,
    input  logic [15:0]             i_gain,
    output bbd_pkg::t_lane_res      o_res
);

    localparam int SW = 16 + FRAC_BITS;
    localparam int AW = ((SW > 32) ? SW : 32) + 1;

    logic signed [15:0]            r_raw;
    logic signed [31:0]            r_filt;
    logic signed [31:0]            n_filt;
    logic [AW-1:0]                 r_dmag;
    logic                          r_dneg;
    logic [AW+15:0]                r_prod;
    logic                          r_pneg;
    logic signed [31:0]            r_next;
    logic [32:0]                   r_mag;
    logic                          r_cneg;
    logic                          r_cnz;
    logic [48:0]                   r_gm;
    logic [bbd_pkg::NUM_W-1:0]     r_num;

    logic signed [AW-1:0]          w_s;
    logic signed [AW-1:0]          w_prev;
    logic signed [AW-1:0]          w_d;
    logic [AW+16:0]                w_psum;
    logic [AW:0]                   w_inc;
    logic signed [AW+1:0]          w_incs;
    logic signed [AW+1:0]          w_sum;
    logic signed [32:0]            w_chg;
    logic signed [SW-1:0]          w_seed;

    // scaled sample and difference to the filter state
    assign w_s    = AW'($signed({r_raw, {FRAC_BITS{1'b0}}}));
    assign w_prev = AW'(r_filt);
    assign w_d    = w_s - w_prev;

    // rounded-down increment, added with saturation
    assign w_psum = (AW+17)'(r_prod) + (AW+17)'(r_pneg ? 16'hffff : 16'h0000);
    assign w_inc  = w_psum[AW+16:16];
    assign w_incs = r_pneg ? -$signed({1'b0, w_inc}) : $signed({1'b0, w_inc});
    assign w_sum  = (AW+2)'(w_prev) + w_incs;

    // filter change after saturation
    assign w_chg = 33'(r_next) - 33'(r_filt);

    // first sample seeds the filter
    assign w_seed = $signed({i_raw, {FRAC_BITS{1'b0}}});

    // filter state update
    always_comb begin
        n_filt = r_filt;
        if (i_ctl.seed) begin
            n_filt = bbd_pkg::sat32(64'(w_seed));
        end else if (i_ctl.commit) begin
            n_filt = r_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt <= '0;
        end else begin
            r_filt <= n_filt;
        end
    end

    // sample capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_raw <= i_raw;
        end
    end

    // free-running datapath stages, settled by the sequencer's step count
    always_ff @(posedge i_clk) begin
        r_dneg <= w_d[AW-1];
        r_dmag <= w_d[AW-1] ? AW'(-w_d) : AW'(w_d);
        r_prod <= (AW+16)'(i_alpha) * (AW+16)'(r_dmag);
        r_pneg <= r_dneg;
        r_next <= bbd_pkg::sat32(64'(w_sum));
        r_cneg <= w_chg[32];
        r_cnz  <= (w_chg != 33'sd0);
        r_mag  <= w_chg[32] ? 33'(-w_chg) : 33'(w_chg);
        r_gm   <= 49'(i_gain) * 49'(r_mag);
        r_num  <= bbd_pkg::NUM_W'(r_gm) * bbd_pkg::NUM_W'(bbd_pkg::SCALE_MS);
    end

    assign o_res.num     = r_num;
    assign o_res.neg     = r_cneg;
    assign o_res.nonzero = r_cnz;

endmodule

[sv/bbd_merge.sv]
// bbd_merge: threshold compare for all lanes and the result register
// depends on bbd_pkg
module bbd_merge #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bbd_pkg::t_lane_res            i_res [3],
    input  logic [bbd_pkg::BOUND_W-1:0]   i_bound,
    input  logic                          i_commit,
    input  logic                          i_ready,
    output logic                          o_valid,
    output bbd_pkg::t_coil                o_coil [3]
);

    localparam int SHIFT = 8 + FRAC_BITS;

    logic                  r_valid;
    logic                  n_valid;
    bbd_pkg::t_coil        r_coil [3];
    bbd_pkg::t_coil        w_coil [3];
    logic [bbd_pkg::BOUND_W-1:0] w_scaled [3];

    // moment beyond threshold: num >= (threshold + 1) * dt * 2^SHIFT
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_scaled[l] = bbd_pkg::BOUND_W'(i_res[l].num >> SHIFT);
            if (i_res[l].nonzero && (w_scaled[l] >= i_bound)) begin
                w_coil[l] = i_res[l].neg ? bbd_pkg::COIL_FWD : bbd_pkg::COIL_REV;
            end else begin
                w_coil[l] = bbd_pkg::COIL_OFF;
            end
        end
    end

    // result register valid
    always_comb begin
        n_valid = r_valid;
        if (i_commit) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_coil <= w_coil;
        end
    end

    assign o_valid = r_valid;
    assign o_coil  = r_coil;

endmodule

[sv/bdot_bang_bang_detumble.sv]
// bdot_bang_bang_detumble: top level, sequencer, configuration and shared bound
// depends on bbd_pkg, bbd_lane, bbd_merge
//
// Usage
//   Input channel (i_valid / o_ready) carries one magnetometer item: three
//   raw axis readings and a millisecond tick. Output channel (o_valid /
//   i_ready) carries one coil item: drive code per axis.
//   The first item after reset only seeds the filters and gives no result.
//   An item whose tick equals the previous tick is dropped with no result.
//   Every other item gives exactly one result.
//   The three axis lanes run in parallel; each item passes in turn through
//   the alpha multiply, saturating add, gain multiply, scale by 1000 and
//   threshold compare, and a new item is accepted only once the last one
//   has been written to the output register.
//   Seeding and dropped items leave the sequencer in idle.
//   A finished result sits in the output register; while the receiver stalls
//   the next item may be accepted and worked on, and it waits in its last
//   step until the register is free.
//   Reset (synchronous, active low) clears the filters, the last tick, the
//   started flag, and loads default alpha, gain and threshold. Configuration
//   writes take effect at once; the user makes them only while idle, unchecked.
module bdot_bang_bang_detumble #(
    parameter int FILTER_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_field_x,
    input  logic signed [15:0]  i_field_y,
    input  logic signed [15:0]  i_field_z,
    input  logic [31:0]         i_tick_ms,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_coil_x,
    output logic [1:0]          o_coil_y,
    output logic [1:0]          o_coil_z,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);

    bbd_pkg::t_state            r_state;
    bbd_pkg::t_state            n_state;
    logic [15:0]                r_alpha;
    logic [15:0]                r_gain;
    logic [31:0]                r_threshold;
    logic                       r_started;
    logic [31:0]                r_last_tick;
    logic [31:0]                r_tick;
    logic [31:0]                r_dt;
    logic [bbd_pkg::BOUND_W-1:0] r_bound;

    logic                       w_accept;
    logic [31:0]                w_dt;
    logic                       w_out_free;
    bbd_pkg::t_lane_ctl         w_ctl;
    bbd_pkg::t_lane_res         w_res [3];
    logic signed [15:0]         w_raw [3];
    bbd_pkg::t_coil             w_coil [3];

    assign w_accept   = i_valid && o_ready;
    assign w_dt       = i_tick_ms - r_last_tick;
    assign w_out_free = !o_valid || i_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= bbd_pkg::ALPHA_RST;
            r_gain      <= bbd_pkg::GAIN_RST;
            r_threshold <= bbd_pkg::THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bbd_pkg::REG_ALPHA:     r_alpha     <= i_cfg_data[15:0];
                bbd_pkg::REG_GAIN:      r_gain      <= i_cfg_data[15:0];
                bbd_pkg::REG_THRESHOLD: r_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bbd_pkg::S_IDLE: begin
                if (w_accept && r_started && (w_dt != 32'd0)) begin
                    n_state = bbd_pkg::S_ABS;
                end
            end
            bbd_pkg::S_ABS:   n_state = bbd_pkg::S_ALPHA;
            bbd_pkg::S_ALPHA: n_state = bbd_pkg::S_FILT;
            bbd_pkg::S_FILT:  n_state = bbd_pkg::S_CHG;
            bbd_pkg::S_CHG:   n_state = bbd_pkg::S_GAIN;
            bbd_pkg::S_GAIN:  n_state = bbd_pkg::S_SCALE;
            bbd_pkg::S_SCALE: n_state = bbd_pkg::S_DONE;
            bbd_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = bbd_pkg::S_IDLE;
                end
            end
            default: n_state = bbd_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_ready      = 1'b0;
        w_ctl.load   = 1'b0;
        w_ctl.seed   = 1'b0;
        w_ctl.commit = 1'b0;
        unique case (r_state)
            bbd_pkg::S_IDLE: begin
                o_ready    = 1'b1;
                w_ctl.seed = w_accept && !r_started;
                w_ctl.load = w_accept && r_started && (w_dt != 32'd0);
            end
            bbd_pkg::S_DONE: begin
                w_ctl.commit = w_out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bbd_pkg::S_IDLE;
            r_started   <= 1'b0;
            r_last_tick <= '0;
        end else begin
            r_state <= n_state;
            if (w_ctl.seed) begin
                r_started   <= 1'b1;
                r_last_tick <= i_tick_ms;
            end else if (w_ctl.commit) begin
                r_last_tick <= r_tick;
            end
        end
    end

    // elapsed time and the shared threshold bound
    always_ff @(posedge i_clk) begin
        if (w_ctl.load) begin
            r_dt   <= w_dt;
            r_tick <= i_tick_ms;
        end
        r_bound <= bbd_pkg::BOUND_W'(33'(r_threshold) + 33'd1) * bbd_pkg::BOUND_W'(r_dt);
    end

    assign w_raw[0] = i_field_x;
    assign w_raw[1] = i_field_y;
    assign w_raw[2] = i_field_z;

    // one lane per axis
    for (genvar g = 0; g < 3; g++) begin : g_lane
        bbd_lane #(
            .FRAC_BITS (FILTER_FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_raw   (w_raw[g]),
            .i_alpha (r_alpha),
            .i_gain  (r_gain),
            .o_res   (w_res[g])
        );
    end

    bbd_merge #(
        .FRAC_BITS (FILTER_FRAC_BITS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res    (w_res),
        .i_bound  (r_bound),
        .i_commit (w_ctl.commit),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_coil   (w_coil)
    );

    assign o_coil_x = w_coil[0];
    assign o_coil_y = w_coil[1];
    assign o_coil_z = w_coil[2];

    // a result is written only into a free output register
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.commit |-> (!o_valid || i_ready))
        else $error("result written over a pending item");

    // the seeding item starts no work and sets started
    a_seed_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_started) |=> (r_started && r_state == bbd_pkg::S_IDLE))
        else $error("seeding item did not return to idle");

    // an item with no elapsed time is dropped
    a_zero_dt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_started && w_dt == 32'd0) |=> (r_state == bbd_pkg::S_IDLE))
        else $error("zero interval item was processed");

    // coil code three never leaves the block
    a_coil_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_coil_x == bbd_pkg::COIL_OFF || o_coil_x == bbd_pkg::COIL_FWD
                      || o_coil_x == bbd_pkg::COIL_REV)
                  && (o_coil_y == bbd_pkg::COIL_OFF || o_coil_y == bbd_pkg::COIL_FWD
                      || o_coil_y == bbd_pkg::COIL_REV)
                  && (o_coil_z == bbd_pkg::COIL_OFF || o_coil_z == bbd_pkg::COIL_FWD
                      || o_coil_z == bbd_pkg::COIL_REV)))
        else $error("invalid coil code");

endmodule
